@@ src/catmull_rom_spline_eval_unit_defines.svh @@
// Assertion macros for the spline evaluator checkers.
// Both expect clk and rst_n in the scope where they are used.
`ifndef CATMULL_ROM_SPLINE_EVAL_UNIT_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CRS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CRS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/crs_pkg.sv @@
`timescale 1ns / 1ps

package crs_pkg;

    // input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // tension format, Q1.8
    localparam int             TENS_W     = 9;
    localparam int             TENS_FRAC  = 8;
    localparam logic [TENS_W-1:0] TENS_ONE   = 9'd256;
    localparam logic [TENS_W-1:0] TENS_RESET = 9'd128;

    // extra bits of the coefficient / accumulator words over a point, TENS_FRAC of them fraction bits
    localparam int ACC_GUARD = 14;

    // window fill
    localparam logic [2:0] FILL_FULL = 3'd4;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_MUL_DC,
        OP_WR_C,
        OP_MUL_DA,
        OP_WR_A,
        OP_MUL_DB,
        OP_WR_B,
        OP_MUL_AU,
        OP_ACC_PB,
        OP_MUL_3AU,
        OP_ACC_T2B,
        OP_MUL_PU,
        OP_ACC_PC,
        OP_MUL_TU,
        OP_ACC_TC,
        OP_ACC_PD,
        OP_OUT,
        OP_OUT_NULL
    } crs_op_t;

    typedef struct packed {
        logic    push;
        logic    load_u;
        logic    cfg_wr;
        crs_op_t op;
    } crs_cmd_t;

    typedef struct packed {
        logic out_free;
    } crs_sts_t;

    localparam int COEF_STEPS = 6;
    localparam int EVAL_STEPS = 10;
    localparam int STEP_W     = $clog2(EVAL_STEPS);
    localparam int COEF_IDX_W = $clog2(COEF_STEPS);

    // coefficient pass: c, a, b (multiply, then write)
    localparam crs_op_t COEF_SEQ [COEF_STEPS] = '{
        OP_MUL_DC, OP_WR_C,
        OP_MUL_DA, OP_WR_A,
        OP_MUL_DB, OP_WR_B
    };

    // Horner: p=au+b, t=3au+2b, p=pu+c, t=tu+c, p=pu+d
    localparam crs_op_t EVAL_SEQ [EVAL_STEPS] = '{
        OP_MUL_AU,  OP_ACC_PB,
        OP_MUL_3AU, OP_ACC_T2B,
        OP_MUL_PU,  OP_ACC_PC,
        OP_MUL_TU,  OP_ACC_TC,
        OP_MUL_PU,  OP_ACC_PD
    };

endpackage

@@ src/crs_req_if.sv @@
`timescale 1ns / 1ps

interface crs_req_if #(
    parameter int COORD_WIDTH = 24,
    parameter int U_FRAC_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [U_FRAC_BITS:0]          param_u;

    modport source (
        output valid, cmd, point_x, point_y, point_z, param_u,
        input  ready
    );
    modport sink (
        input  valid, cmd, point_x, point_y, point_z, param_u,
        output ready
    );
endinterface

@@ src/crs_rsp_if.sv @@
`timescale 1ns / 1ps

interface crs_rsp_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          valid_res;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tan_x;
    logic signed [COORD_WIDTH-1:0] tan_y;
    logic signed [COORD_WIDTH-1:0] tan_z;

    modport source (
        output valid, valid_res, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
        input  ready
    );
    modport sink (
        input  valid, valid_res, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
        output ready
    );
endinterface

@@ src/crs_cfg_if.sv @@
`timescale 1ns / 1ps

interface crs_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] tension;

    modport source (
        output valid, tension,
        input  ready
    );
    modport sink (
        input  valid, tension,
        output ready
    );
endinterface

@@ src/crs_lane.sv @@
`timescale 1ns / 1ps

module crs_lane
    import crs_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int U_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  crs_cmd_t                      cmd,
    input  logic signed [COORD_WIDTH-1:0] point,
    input  logic [U_FRAC_BITS:0]          u,
    input  logic [TENS_W-1:0]             s,
    output logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH-1:0] tan
);

    localparam int AW = COORD_WIDTH + ACC_GUARD;
    localparam int BW = U_FRAC_BITS + 2;
    localparam int PW = AW + BW;
    localparam int HW = AW - COORD_WIDTH - TENS_FRAC + 1;
    localparam logic signed [PW-1:0] MUL_HALF = PW'(1) << (U_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] FIN_HALF = AW'(1) << (TENS_FRAC - 1);

    logic signed [COORD_WIDTH-1:0] win_reg [4];
    logic signed [AW-1:0]          a_reg;
    logic signed [AW-1:0]          b_reg;
    logic signed [AW-1:0]          c_reg;
    logic signed [AW-1:0]          p_reg;
    logic signed [AW-1:0]          t_reg;
    logic signed [PW-1:0]          prod_reg;

    logic signed [AW-1:0] p0, p1, p2, p3;
    logic signed [AW-1:0] diff_c, diff_a, diff_b, d12;
    logic signed [AW-1:0] fix_a, fix_b, a3;
    logic signed [AW-1:0] op_a;
    logic [BW-1:0]        op_b_raw;
    logic signed [BW-1:0] op_b;
    logic                 use_u;
    logic signed [PW-1:0] prod_rnd;
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] prod_lo;

    // window, oldest at index 0
    always_ff @(posedge clk) begin
        if (cmd.push) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= point;
        end
    end

    assign p0 = AW'(win_reg[0]);
    assign p1 = AW'(win_reg[1]);
    assign p2 = AW'(win_reg[2]);
    assign p3 = AW'(win_reg[3]);

    // tension-scaled parts of the basis product
    assign diff_c = p2 - p0;
    assign diff_a = p3 - p0 - p1 + p2;
    assign diff_b = (p0 <<< 1) + p1 - (p2 <<< 1) - p3;
    assign d12    = p1 - p2;
    // fixed parts: 2*(P1-P2) and 3*(P2-P1), in Q.8 of tension
    assign fix_a  = d12 <<< (TENS_FRAC + 1);
    assign fix_b  = -((d12 <<< (TENS_FRAC + 1)) + (d12 <<< TENS_FRAC));
    assign a3     = (a_reg <<< 1) + a_reg;

    always_comb begin
        op_a  = '0;
        use_u = 1'b1;
        case (cmd.op)
            OP_MUL_DC:  begin op_a = diff_c; use_u = 1'b0; end
            OP_MUL_DA:  begin op_a = diff_a; use_u = 1'b0; end
            OP_MUL_DB:  begin op_a = diff_b; use_u = 1'b0; end
            OP_MUL_AU:  op_a = a_reg;
            OP_MUL_3AU: op_a = a3;
            OP_MUL_PU:  op_a = p_reg;
            OP_MUL_TU:  op_a = t_reg;
            default:    op_a = '0;
        endcase
    end

    assign op_b_raw = use_u ? BW'(u) : BW'(s);
    assign op_b     = op_b_raw;

    always_ff @(posedge clk) begin
        prod_reg <= PW'(op_a) * PW'(op_b);
    end

    // round half up back to the coefficient format
    assign prod_rnd = prod_reg + MUL_HALF;
    assign rnd      = prod_rnd[AW+U_FRAC_BITS-1:U_FRAC_BITS];
    assign prod_lo  = prod_reg[AW-1:0];

    always_ff @(posedge clk) begin
        case (cmd.op)
            OP_WR_C:    c_reg <= prod_lo;
            OP_WR_A:    a_reg <= prod_lo + fix_a;
            OP_WR_B:    b_reg <= prod_lo + fix_b;
            OP_ACC_PB:  p_reg <= rnd + b_reg;
            OP_ACC_T2B: t_reg <= rnd + (b_reg <<< 1);
            OP_ACC_PC:  p_reg <= rnd + c_reg;
            OP_ACC_TC:  t_reg <= rnd + c_reg;
            OP_ACC_PD:  p_reg <= rnd + (p1 <<< TENS_FRAC);
            default:    ;
        endcase
    end

    function automatic logic [COORD_WIDTH-1:0] finish(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] xr;
        logic [HW-1:0]        hi;
        xr = x + FIN_HALF;
        hi = xr[AW-1:COORD_WIDTH+TENS_FRAC-1];
        if ((&hi) || !(|hi)) begin
            finish = xr[COORD_WIDTH+TENS_FRAC-1:TENS_FRAC];
        end else if (xr[AW-1]) begin
            finish = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            finish = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    assign pos = finish(p_reg);
    assign tan = finish(t_reg);

endmodule

@@ src/crs_datapath.sv @@
`timescale 1ns / 1ps

module crs_datapath
    import crs_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int U_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crs_cmd_t                      cmd,
    output crs_sts_t                      sts,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [U_FRAC_BITS:0]          param_u,
    input  logic [TENS_W-1:0]             tension,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic                          valid_res,
    output logic signed [COORD_WIDTH-1:0] pos_x,
    output logic signed [COORD_WIDTH-1:0] pos_y,
    output logic signed [COORD_WIDTH-1:0] pos_z,
    output logic signed [COORD_WIDTH-1:0] tan_x,
    output logic signed [COORD_WIDTH-1:0] tan_y,
    output logic signed [COORD_WIDTH-1:0] tan_z
);

    localparam logic [U_FRAC_BITS:0] U_ONE = (U_FRAC_BITS+1)'(1) << U_FRAC_BITS;

    logic [TENS_W-1:0]      tension_reg;
    logic [U_FRAC_BITS:0]   u_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   res_valid_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg [3];
    logic signed [COORD_WIDTH-1:0] tan_reg [3];

    logic [TENS_W-1:0]             s_clamp;
    logic signed [COORD_WIDTH-1:0] pt   [3];
    logic signed [COORD_WIDTH-1:0] pos_l [3];
    logic signed [COORD_WIDTH-1:0] tan_l [3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tension_reg <= TENS_RESET;
        end else if (cmd.cfg_wr) begin
            tension_reg <= tension;
        end
    end

    // tension above one acts as one
    assign s_clamp = tension_reg[TENS_W-1] ? TENS_ONE : tension_reg;

    always_ff @(posedge clk) begin
        if (cmd.load_u) begin
            u_reg <= param_u[U_FRAC_BITS] ? U_ONE : param_u;
        end
    end

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        crs_lane #(
            .COORD_WIDTH(COORD_WIDTH),
            .U_FRAC_BITS(U_FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .cmd   (cmd),
            .point (pt[g]),
            .u     (u_reg),
            .s     (s_clamp),
            .pos   (pos_l[g]),
            .tan   (tan_l[g])
        );
    end

    // output register
    assign sts.out_free = !out_valid_reg || rsp_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (rsp_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.op == OP_OUT || cmd.op == OP_OUT_NULL) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.op == OP_OUT) begin
            res_valid_reg <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                pos_reg[k] <= pos_l[k];
                tan_reg[k] <= tan_l[k];
            end
        end else if (cmd.op == OP_OUT_NULL) begin
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                pos_reg[k] <= '0;
                tan_reg[k] <= '0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign valid_res = res_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign tan_x     = tan_reg[0];
    assign tan_y     = tan_reg[1];
    assign tan_z     = tan_reg[2];

endmodule

@@ src/crs_ctrl.sv @@
`timescale 1ns / 1ps

module crs_ctrl
    import crs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_cmd,
    input  logic     cfg_valid,
    input  crs_sts_t sts,
    output logic     req_ready,
    output logic     cfg_ready,
    output crs_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COEF = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } crs_state_t;

    crs_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        fill_reg, fill_next;
    logic              full;

    assign full = (fill_reg == FILL_FULL);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        fill_next  = fill_reg;
        cmd.push   = 1'b0;
        cmd.load_u = 1'b0;
        cmd.cfg_wr = 1'b0;
        cmd.op     = OP_IDLE;
        req_ready  = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                req_ready = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_wr = 1'b1;
                    if (full) begin
                        state_next = ST_COEF;
                        step_next  = '0;
                    end
                end else if (req_valid) begin
                    if (req_cmd == CMD_PUSH) begin
                        cmd.push = 1'b1;
                        if (!full) begin
                            fill_next = fill_reg + 3'd1;
                        end
                        // window is full after this push
                        if (fill_reg >= FILL_FULL - 3'd1) begin
                            state_next = ST_COEF;
                            step_next  = '0;
                        end
                    end else begin
                        cmd.load_u = 1'b1;
                        step_next  = '0;
                        state_next = full ? ST_EVAL : ST_DONE;
                    end
                end
            end
            ST_COEF: begin
                cmd.op = COEF_SEQ[step_reg[COEF_IDX_W-1:0]];
                if (step_reg == STEP_W'(COEF_STEPS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EVAL: begin
                cmd.op = EVAL_SEQ[step_reg];
                if (step_reg == STEP_W'(EVAL_STEPS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = full ? OP_OUT : OP_OUT_NULL;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

@@ src/catmull_rom_spline_eval_unit.sv @@
`timescale 1ns / 1ps

// Cardinal (Catmull-Rom) spline evaluator. A push transaction (cmd 0) shifts a
// signed Q.8 3-D point into a four-point window; once the window is full the
// segment coefficients are rebuilt from it and the tension register (Q1.8,
// 128 = classic Catmull-Rom, values above 256 act as 256). An evaluate
// transaction (cmd 1) returns position and tangent at u (Q1.U_FRAC_BITS,
// values above 1.0 act as 1.0), rounded half up and saturated; with fewer than
// four points it returns valid_res 0 and all-zero fields. Items are taken one at
// a time. A push that leaves the window full also runs the coefficient pass
// (three multiply/write pairs on each axis's multiplier). An evaluate on a full
// window goes through accept, five Horner multiplications, each a multiply step
// and a round/add step on the per-axis multiplier, and a load of the result
// register. A tension write with a full window also runs the coefficient
// pass. The result register lets the next transaction in while an answer
// waits; an evaluate then stalls only before loading the result register,
// until the answer is taken.

module catmull_rom_spline_eval_unit
    import crs_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int U_FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    crs_req_if.sink  req,
    crs_rsp_if.source rsp,
    crs_cfg_if.sink  cfg
);

    crs_cmd_t cmd;
    crs_sts_t sts;

    // controller: handshakes, window fill count, step sequencing
    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .cfg_valid (cfg.valid),
        .sts       (sts),
        .req_ready (req.ready),
        .cfg_ready (cfg.ready),
        .cmd       (cmd)
    );

    // datapath: window, coefficients, multipliers and result register
    crs_datapath #(
        .COORD_WIDTH(COORD_WIDTH),
        .U_FRAC_BITS(U_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .point_x   (req.point_x),
        .point_y   (req.point_y),
        .point_z   (req.point_z),
        .param_u   (req.param_u),
        .tension   (cfg.tension),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .valid_res (rsp.valid_res),
        .pos_x     (rsp.pos_x),
        .pos_y     (rsp.pos_y),
        .pos_z     (rsp.pos_z),
        .tan_x     (rsp.tan_x),
        .tan_y     (rsp.tan_y),
        .tan_z     (rsp.tan_z)
    );

endmodule

@@ src/crs_checker.sv @@
`timescale 1ns / 1ps

`include "catmull_rom_spline_eval_unit_defines.svh"

module crs_checker #(
    parameter int COORD_WIDTH = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   req_cmd,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic                   rsp_valid_res,
    input logic [COORD_WIDTH-1:0] pos_x,
    input logic [COORD_WIDTH-1:0] pos_y,
    input logic [COORD_WIDTH-1:0] pos_z,
    input logic [COORD_WIDTH-1:0] tan_x,
    input logic [COORD_WIDTH-1:0] tan_y,
    input logic [COORD_WIDTH-1:0] tan_z
);

    logic [6*COORD_WIDTH:0] rsp_bits;
    logic                   fields_zero;
    logic                   req_fire;
    logic                   cfg_fire;
    logic                   eval_fire;

    assign rsp_bits    = {rsp_valid_res, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z};
    assign fields_zero = (rsp_bits[6*COORD_WIDTH-1:0] == '0);
    assign req_fire    = req_valid && req_ready;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign eval_fire   = req_fire && req_cmd;

    `CRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits), "stalled result changed")
    `CRS_ASSERT_NOW(a_null_zero, rsp_valid && !rsp_valid_res, fields_zero, "invalid result with nonzero fields")
    `CRS_ASSERT_NOW(a_one_accept, req_fire, !cfg_fire, "item and config write in the same cycle")
    `CRS_ASSERT_NEXT(a_eval_busy, eval_fire, !req_ready && !cfg_ready, "ready right after an evaluate")

endmodule

bind catmull_rom_spline_eval_unit crs_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_crs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_cmd       (req.cmd),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_valid_res (rsp.valid_res),
    .pos_x         (rsp.pos_x),
    .pos_y         (rsp.pos_y),
    .pos_z         (rsp.pos_z),
    .tan_x         (rsp.tan_x),
    .tan_y         (rsp.tan_y),
    .tan_z         (rsp.tan_z)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import crs_pkg::*;

    localparam int COORD_W         = 24;
    localparam int U_FRAC          = 16;
    localparam int U_ONE           = 1 << U_FRAC;
    localparam int DRAIN_CYCLES    = 30;      // > longest busy stretch (evaluate, or push with coefficient pass)
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RUN_LIMIT_NS    = 4_000_000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [U_FRAC:0]           param_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // one expected evaluate result
    typedef struct packed {
        logic               valid_res;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] tan_x;
        logic [COORD_W-1:0] tan_y;
        logic [COORD_W-1:0] tan_z;
    } curve_sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    crs_req_if #(.COORD_WIDTH(COORD_W), .U_FRAC_BITS(U_FRAC)) req_if ();
    crs_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_if ();
    crs_cfg_if cfg_if ();

    catmull_rom_spline_eval_unit #(
        .COORD_WIDTH(COORD_W),
        .U_FRAC_BITS(U_FRAC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // Spline predictor: own copy of window, fill, coefficients, tension
    // ------------------------------------------------------------------
    coord_t        ctrl_pts [4][3];       // [0] oldest .. [3] newest
    int unsigned   pts_held;
    longint        seg_coef [4][3];       // a, b, c, d per axis, Q.16
    logic [8:0]    tension_q8;
    curve_sample_t pending_samples [$];

    int    mismatch_count = 0;
    bit    idle_en;
    int    hold_req;
    string field_name [7] = '{"valid_res", "pos_x", "pos_y", "pos_z",
                              "tan_x", "tan_y", "tan_z"};

    // x * u / 2^U_FRAC, rounded half up, exact
    function automatic longint scale_by_u(longint x, longint u);
        longint hi, lo;
        hi = x >>> U_FRAC;
        lo = x & ((64'sd1 << U_FRAC) - 1);
        return hi * u + ((lo * u + (64'sd1 << (U_FRAC - 1))) >>> U_FRAC);
    endfunction

    // drop the 8 extra fraction bits (half up), then saturate
    function automatic logic [COORD_W-1:0] round_to_coord(longint x);
        longint r, lim;
        lim = 64'sd1 << (COORD_W - 1);
        r   = (x + (64'sd1 << (TENS_FRAC - 1))) >>> TENS_FRAC;
        if (r > lim - 1)
            r = lim - 1;
        else if (r < -lim)
            r = -lim;
        return r[COORD_W-1:0];
    endfunction

    // tension basis matrix times the window
    function automatic void rebuild_segment_coeffs();
        longint s, one, acc;
        longint basis [4][4];
        int r, j, k;
        s   = (tension_q8 > TENS_ONE) ? TENS_ONE : tension_q8;
        one = TENS_ONE;
        basis[0] = '{-s,    2*one - s, s - 2*one,   s};
        basis[1] = '{2*s,   s - 3*one, 3*one - 2*s, -s};
        basis[2] = '{-s,    0,         s,           0};
        basis[3] = '{0,     one,       0,           0};
        for (r = 0; r < 4; r++)
            for (k = 0; k < 3; k++)
            begin
                acc = 0;
                for (j = 0; j < 4; j++)
                    acc += basis[r][j] * longint'(ctrl_pts[j][k]);
                seg_coef[r][k] = acc;
            end
    endfunction

    // apply one accepted request transaction; evaluates queue a sample
    function automatic void advance_spline_model(logic cmd, coord_t x, coord_t y,
                                                 coord_t z, param_t u_in);
        curve_sample_t      smp;
        longint             u, p, t;
        logic [COORD_W-1:0] pos [3];
        logic [COORD_W-1:0] tng [3];
        int                 k;
        if (cmd == CMD_PUSH)
        begin
            for (k = 0; k < 3; k++)
            begin
                ctrl_pts[0][k] = ctrl_pts[1][k];
                ctrl_pts[1][k] = ctrl_pts[2][k];
                ctrl_pts[2][k] = ctrl_pts[3][k];
            end
            ctrl_pts[3][0] = x;
            ctrl_pts[3][1] = y;
            ctrl_pts[3][2] = z;
            if (pts_held < 4)
                pts_held++;
            if (pts_held == 4)
                rebuild_segment_coeffs();
            return;
        end
        smp = '0;
        if (pts_held == 4)
        begin
            u = (u_in > U_ONE) ? U_ONE : u_in;   // u above 1.0 clamps
            for (k = 0; k < 3; k++)
            begin
                p = scale_by_u(seg_coef[0][k], u) + seg_coef[1][k];
                p = scale_by_u(p, u) + seg_coef[2][k];
                p = scale_by_u(p, u) + seg_coef[3][k];
                t = scale_by_u(3 * seg_coef[0][k], u) + 2 * seg_coef[1][k];
                t = scale_by_u(t, u) + seg_coef[2][k];
                pos[k] = round_to_coord(p);
                tng[k] = round_to_coord(t);
            end
            smp.valid_res = 1'b1;
            smp.pos_x = pos[0];
            smp.pos_y = pos[1];
            smp.pos_z = pos[2];
            smp.tan_x = tng[0];
            smp.tan_y = tng[1];
            smp.tan_z = tng[2];
        end
        pending_samples.push_back(smp);
    endfunction

    // ------------------------------------------------------------------
    // Random field values
    // ------------------------------------------------------------------
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            1, 2, 3: return coord_t'($urandom);
            4, 5:    return coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
            default: return coord_t'($urandom_range(0, 65535)) - coord_t'(32768);
        endcase
    endfunction

    function automatic param_t rand_param_u();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return param_t'(U_ONE);
            2:       return param_t'($urandom_range(U_ONE + 1, 2 * U_ONE - 1));
            default: return param_t'($urandom_range(0, U_ONE - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. Drive on falling edge, sample ready on rising edge.
    // valid stays high after acceptance; whatever follows starts with
    // a falling edge and either loads the next item or drops valid.
    // ------------------------------------------------------------------
    task automatic send_item(logic cmd, coord_t x, coord_t y, coord_t z, param_t u);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            req_if.valid   = 1'b0;
            req_if.cmd     = 1'($urandom);       // junk while idle
            req_if.point_x = coord_t'($urandom);
            req_if.param_u = param_t'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid   = 1'b1;
        req_if.cmd     = cmd;
        req_if.point_x = x;
        req_if.point_y = y;
        req_if.point_z = z;
        req_if.param_u = u;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        advance_spline_model(cmd, x, y, z, u);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 35)
            send_item(CMD_PUSH, rand_coord(), rand_coord(), rand_coord(), rand_param_u());
        else
            send_item(CMD_EVAL, rand_coord(), rand_coord(), rand_coord(), rand_param_u());
    endtask

    task automatic req_quiet();
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    // Tension write, only with the block idle: all results back, then a
    // drain in case a trailing push is still rebuilding coefficients.
    task automatic write_tension(logic [8:0] value);
        req_quiet();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid   = 1'b1;
        cfg_if.tension = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        tension_q8 = value;
        if (pts_held == 4)
            rebuild_segment_coeffs();   // full window recomputes at once
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: random ready bursts, plus a long counted hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (hold_req - 1) @(negedge clk);
                hold_req = 0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13);
                rsp_if.ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                rsp_if.ready = 1'b1;
        end
    end

    // Result check: every response transaction against the oldest sample
    always @(posedge clk)
    begin
        curve_sample_t      want;
        logic [COORD_W-1:0] want_f [7];
        logic [COORD_W-1:0] got_f  [7];
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_f = '{COORD_W'(rsp_if.valid_res), rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z,
                      rsp_if.tan_x, rsp_if.tan_y, rsp_if.tan_z};
            if (pending_samples.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual %h %h %h %h",
                         $time, got_f[0], got_f[1], got_f[2], got_f[3]);
                mismatch_count++;
            end
            else
            begin
                want   = pending_samples.pop_front();
                want_f = '{COORD_W'(want.valid_res), want.pos_x, want.pos_y, want.pos_z,
                           want.tan_x, want.tan_y, want.tan_z};
                for (int k = 0; k < 7; k++)
                    if (got_f[k] !== want_f[k])
                    begin
                        $display("%0t: %s expected %h actual %h",
                                 $time, field_name[k], want_f[k], got_f[k]);
                        mismatch_count++;
                    end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Evaluate with 0..3 points held must come back invalid and zeroed; a last one follows with the window full.
    task automatic test_window_fill();
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE / 2));
        send_item(CMD_PUSH, coord_t'(10 * 256), coord_t'(-3 * 256), coord_t'(1), '1);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE));
        send_item(CMD_PUSH, coord_t'(20 * 256), coord_t'(5 * 256), coord_t'(-77), '0);
        send_item(CMD_EVAL, 0, 0, 0, '0);
        send_item(CMD_PUSH, coord_t'(-40 * 256), coord_t'(12 * 256), coord_t'(300), '0);
        send_item(CMD_EVAL, '1, '1, '1, '1);
        send_item(CMD_PUSH, coord_t'(7 * 256 + 128), coord_t'(-1), coord_t'(65535), '0);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE / 2));
    endtask

    // Alternating full-scale points drive some outputs into saturation;
    // pushes here all land on a full window and shift the oldest out.
    task automatic test_saturation_extremes();
        send_item(CMD_PUSH, COORD_MAX, COORD_MIN, COORD_MAX, '0);
        send_item(CMD_PUSH, COORD_MIN, COORD_MAX, COORD_MIN, '0);
        send_item(CMD_PUSH, COORD_MAX, COORD_MIN, COORD_MAX, '0);
        send_item(CMD_PUSH, COORD_MIN, COORD_MAX, COORD_MIN, '0);
        send_item(CMD_EVAL, 0, 0, 0, '0);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE));
        send_item(CMD_EVAL, 0, 0, 0, '1);                 // u above 1.0
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE / 2));
    endtask

    // Zero, all ones (above one), exactly one, just above one; each write
    // lands on a full window so coefficients rebuild immediately.
    task automatic test_tension_extremes();
        write_tension(9'd0);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE / 3));
        write_tension(9'h1FF);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(U_ONE / 3));
        write_tension(TENS_ONE);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(3 * U_ONE / 4));
        write_tension(TENS_ONE + 9'd1);
        send_item(CMD_EVAL, 0, 0, 0, param_t'(3 * U_ONE / 4));
    endtask

    // Output held off long enough that the result register fills and
    // the request side backs up while items keep coming.
    task automatic test_output_backpressure();
        hold_req = HOLD_OFF_CYCLES;
        repeat (40) send_random_item();
    endtask

    task automatic test_random_segments(int n_items, logic [8:0] tension);
        write_tension(tension);
        repeat (n_items) send_random_item();
    endtask

    // Last stretch: no idle cycles on either side.
    task automatic test_streaming_no_idle();
        write_tension(9'($urandom_range(0, 511)));
        idle_en = 1'b0;
        repeat (120) send_random_item();
    endtask

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_PUSH;
        req_if.point_x = '0;
        req_if.point_y = '0;
        req_if.point_z = '0;
        req_if.param_u = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.tension = TENS_RESET;
        idle_en        = 1'b1;
        hold_req       = 0;
        pts_held       = 0;
        tension_q8     = TENS_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_window_fill();
        test_saturation_extremes();
        test_tension_extremes();
        test_output_backpressure();
        test_random_segments(150, TENS_RESET);
        test_random_segments(150, 9'd0);
        test_random_segments(150, TENS_ONE);
        test_random_segments(150, 9'h1FF);
        test_random_segments(150, 9'($urandom_range(0, 511)));
        test_random_segments(150, 9'($urandom_range(1, 255)));
        test_streaming_no_idle();

        req_quiet();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard, well beyond the slowest legal run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still pending", $time, pending_samples.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
